[src/mcspg_pkg.sv]
// Package for the multi-channel step pulse generator: types, widths and codes.
`timescale 1ns / 1ps
package mcspg_pkg;

    localparam int CHANNELS        = 16;
    localparam int STEP_COUNT_BITS = 24;

    localparam int CHAN_W   = 4;
    localparam int CODE_W   = 32;
    localparam int PERIOD_W = 16;
    localparam int COUNT_W  = 24;
    localparam int PIN_W    = 16;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_LOAD     = 1'b1;
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_DONE   = 1'b1;

    typedef struct packed {
        logic                opcode;
        logic [CHAN_W-1:0]   channel;
        logic                direction;
        logic [CODE_W-1:0]   job_code;
        logic [PERIOD_W-1:0] period;
        logic [COUNT_W-1:0]  step_count;
    } item_t;

    typedef struct packed {
        logic                kind;
        logic [CHAN_W-1:0]   done_channel;
        logic [CODE_W-1:0]   done_code;
        logic [PIN_W-1:0]    step_pins;
        logic [PIN_W-1:0]    enable_pins;
        logic [PIN_W-1:0]    dir_pins;
        logic                last;
    } result_t;

    // per-cell control, shared by every cell of the row
    typedef struct packed {
        logic accept;
        logic load;
        logic shift;
    } cell_ctrl_t;

    // done report travelling down the row toward cell 0
    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
    } rpt_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STATUS,
        ST_DRAIN
    } state_t;

endpackage

[src/mcspg_cell.sv]
// One channel cell: step timing state, pin levels and one stage of the report chain.
`timescale 1ns / 1ps
module mcspg_cell import mcspg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       sel,
    input  item_t      item,
    input  rpt_t       rpt_in,
    output rpt_t       rpt_out,
    output logic       step_pin,
    output logic       enable_pin,
    output logic       dir_pin
);

    logic [PERIOD_W-1:0]        period_reg, period_next;
    logic [PERIOD_W-1:0]        time_reg, time_next;
    logic [STEP_COUNT_BITS-1:0] steps_reg, steps_next;
    logic [STEP_COUNT_BITS-1:0] steps_dec;
    logic [STEP_COUNT_BITS-1:0] load_steps;
    logic [CODE_W-1:0]          code_reg, code_next;
    logic                       step_reg, step_next;
    logic                       enable_reg, enable_next;
    logic                       dir_reg, dir_next;
    logic                       rpt_valid_reg, rpt_valid_next;
    logic [CODE_W-1:0]          rpt_code_reg, rpt_code_next;

    assign steps_dec  = steps_reg - STEP_COUNT_BITS'(1);
    assign load_steps = STEP_COUNT_BITS'(item.step_count);

    always_comb
    begin
        period_next    = period_reg;
        time_next      = time_reg;
        steps_next     = steps_reg;
        code_next      = code_reg;
        step_next      = step_reg;
        enable_next    = enable_reg;
        dir_next       = dir_reg;
        rpt_valid_next = rpt_valid_reg;
        rpt_code_next  = rpt_code_reg;
        if (ctrl.accept)
        begin
            rpt_valid_next = 1'b0;
            rpt_code_next  = code_reg;
            if (ctrl.load)
            begin
                if (sel)
                begin
                    enable_next    = 1'b0;
                    dir_next       = item.direction;
                    code_next      = item.job_code;
                    period_next    = item.period;
                    time_next      = item.period;
                    steps_next     = load_steps;
                    // zero count: done at once, enable stays on
                    rpt_valid_next = (load_steps == '0);
                    rpt_code_next  = item.job_code;
                end
            end
            else if (steps_reg != '0)
            begin
                if (time_reg <= PERIOD_W'(1))
                begin
                    step_next  = ~step_reg;
                    time_next  = period_reg;
                    steps_next = steps_dec;
                    if (steps_dec == '0)
                    begin
                        enable_next    = 1'b1;
                        time_next      = '0;
                        period_next    = '0;
                        rpt_valid_next = 1'b1;
                    end
                end
                else
                begin
                    time_next = time_reg - PERIOD_W'(1);
                end
            end
        end
        else if (ctrl.shift)
        begin
            rpt_valid_next = rpt_in.valid;
            rpt_code_next  = rpt_in.code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= '0;
            time_reg      <= '0;
            steps_reg     <= '0;
            code_reg      <= '0;
            step_reg      <= 1'b0;
            enable_reg    <= 1'b1;
            dir_reg       <= 1'b0;
            rpt_valid_reg <= 1'b0;
        end
        else
        begin
            period_reg    <= period_next;
            time_reg      <= time_next;
            steps_reg     <= steps_next;
            code_reg      <= code_next;
            step_reg      <= step_next;
            enable_reg    <= enable_next;
            dir_reg       <= dir_next;
            rpt_valid_reg <= rpt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rpt_code_reg <= rpt_code_next;
    end

    assign rpt_out.valid = rpt_valid_reg;
    assign rpt_out.code  = rpt_code_reg;
    assign step_pin      = step_reg;
    assign enable_pin    = enable_reg;
    assign dir_pin       = dir_reg;

endmodule

[src/multi_channel_step_pulse_generator_unit.sv]
// Top level of the multi-channel step pulse generator: cell row, report drain and result port.
`timescale 1ns / 1ps
// Usage
//   Command channel: an item (item_t) is taken at a rising edge with start high and
//   busy low. Opcode tick advances every active channel by one time unit; opcode
//   load programs one channel (loads to a channel index past the row are ignored).
//   Result channel: each result (result_t) sits on the result port for one cycle
//   with strobe high. There is no back pressure: the receiver must take it.
//   Every item gives a status result first, then one done report per finished
//   channel in ascending channel order; last marks the final result of the item.
// Timing
//   The status result comes in the cycle after the item is taken. Done reports are
//   moved down the cell row one cell per cycle, and each is shown when it reaches
//   cell 0. busy stays high from the edge that takes the item until the final
//   result has been shown.
// Reset
//   Asynchronous, active low. All channels come up idle with enable pins high
//   (disabled), step and direction pins low, and no results pending.
module multi_channel_step_pulse_generator_unit import mcspg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output logic    strobe,
    output result_t result
);

    state_t                state_reg, state_next;
    logic [CH_IDX_W-1:0]   pos_reg, pos_next;
    cell_ctrl_t            ctrl;
    logic                  accept;
    logic                  shift;
    logic                  tail_any;
    logic                  any_valid;

    rpt_t                  rpt     [CHANNELS];
    rpt_t                  rpt_in  [CHANNELS];
    logic [CHANNELS-1:0]   step_vec;
    logic [CHANNELS-1:0]   enable_vec;
    logic [CHANNELS-1:0]   dir_vec;
    logic [CHANNELS-1:0]   sel_vec;

    assign accept      = start && !busy;
    assign ctrl.accept = accept;
    assign ctrl.load   = (item.opcode == OP_LOAD);
    assign ctrl.shift  = shift;

    // ---- cell row: each cell owns one channel; reports shift toward cell 0 ----
    genvar g;
    generate
        for (g = 0; g < CHANNELS; g++)
        begin : g_cell
            assign sel_vec[g] = (item.channel == CHAN_W'(g));
            if (g == CHANNELS - 1)
            begin : g_end
                assign rpt_in[g] = '0;
            end
            else
            begin : g_mid
                assign rpt_in[g] = rpt[g + 1];
            end
            mcspg_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .sel        (sel_vec[g]),
                .item       (item),
                .rpt_in     (rpt_in[g]),
                .rpt_out    (rpt[g]),
                .step_pin   (step_vec[g]),
                .enable_pin (enable_vec[g]),
                .dir_pin    (dir_vec[g])
            );
        end
    endgenerate

    // any report still waiting behind the head of the row
    always_comb
    begin
        tail_any = 1'b0;
        for (int i = 1; i < CHANNELS; i++)
        begin
            tail_any = tail_any | rpt[i].valid;
        end
    end
    assign any_valid = rpt[0].valid | tail_any;

    // ---- sequencer ----
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_STATUS;
            ST_STATUS: state_next = any_valid ? ST_DRAIN : ST_IDLE;
            ST_DRAIN:  state_next = tail_any ? ST_DRAIN : ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy   = 1'b1;
        strobe = 1'b0;
        shift  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_STATUS:
            begin
                strobe = 1'b1;
            end
            ST_DRAIN:
            begin
                strobe = rpt[0].valid;
                shift  = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    // channel number of the report now at the head of the row
    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
            pos_next = '0;
        else if (shift)
            pos_next = pos_reg + CH_IDX_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

    // ---- result port; pins of channels past the row read idle ----
    always_comb
    begin
        result.step_pins   = '0;
        result.enable_pins = '1;
        result.dir_pins    = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            result.step_pins[i]   = step_vec[i];
            result.enable_pins[i] = enable_vec[i];
            result.dir_pins[i]    = dir_vec[i];
        end
        if (state_reg == ST_DRAIN)
        begin
            result.kind         = KIND_DONE;
            result.done_channel = CHAN_W'(pos_reg);
            result.done_code    = rpt[0].code;
            result.last         = !tail_any;
        end
        else
        begin
            result.kind         = KIND_STATUS;
            result.done_channel = '0;
            result.done_code    = '0;
            result.last         = !any_valid;
        end
    end

    // ---- checks ----
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("result shown while idle");

    a_status_first: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (strobe && result.kind == KIND_STATUS))
        else $error("status result does not follow the item");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.last) |=> !busy)
        else $error("still busy after the final result");

    a_done_order: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.kind == KIND_DONE) |-> $past(busy))
        else $error("done report without a preceding status cycle");

endmodule

[sim/step_pulse_monitor.sv]
// Result checker for the step pulse generator: tracks channel state and compares every result.
`timescale 1ns / 1ps
module step_pulse_monitor import mcspg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  item_t   item,
    input  logic    strobe,
    input  result_t result,
    output int      mismatches,
    output int      outstanding
);

    logic [PERIOD_W-1:0]        period_q   [CHANNELS];
    logic [PERIOD_W-1:0]        countdown  [CHANNELS];
    logic [STEP_COUNT_BITS-1:0] steps_todo [CHANNELS];
    logic [CODE_W-1:0]          code_q     [CHANNELS];
    logic                       step_lvl   [CHANNELS];
    logic                       en_lvl     [CHANNELS];
    logic                       dir_lvl    [CHANNELS];

    result_t due_results [$];

    // pin snapshot after the item's update; channels past the row read idle
    function automatic result_t pin_snapshot();
        result_t r;
        r = '0;
        r.enable_pins = '1;
        for (int i = 0; i < CHANNELS; i++)
        begin
            r.step_pins[i]   = step_lvl[i];
            r.enable_pins[i] = en_lvl[i];
            r.dir_pins[i]    = dir_lvl[i];
        end
        return r;
    endfunction

    task automatic advance_channels(input item_t it);
        logic [CHANNELS-1:0] finished;
        int                  n_done;
        int                  k;
        result_t             r;
        finished = '0;
        n_done   = 0;
        k        = 0;
        if (it.opcode == OP_LOAD)
        begin
            if (it.channel < CHANNELS)
            begin
                en_lvl[it.channel]     = 1'b0;
                dir_lvl[it.channel]    = it.direction;
                code_q[it.channel]     = it.job_code;
                period_q[it.channel]   = it.period;
                countdown[it.channel]  = it.period;
                steps_todo[it.channel] = STEP_COUNT_BITS'(it.step_count);
                // zero count finishes at once, enable stays on
                if (steps_todo[it.channel] == '0)
                begin
                    finished[it.channel] = 1'b1;
                    n_done++;
                end
            end
        end
        else
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (steps_todo[i] != '0)
                begin
                    // countdown of 0 or 1 steps now (zero period steps every tick)
                    if (countdown[i] <= 1)
                    begin
                        step_lvl[i]   = ~step_lvl[i];
                        countdown[i]  = period_q[i];
                        steps_todo[i] = steps_todo[i] - 1'b1;
                        if (steps_todo[i] == '0)
                        begin
                            en_lvl[i]    = 1'b1;
                            countdown[i] = '0;
                            period_q[i]  = '0;
                            finished[i]  = 1'b1;
                            n_done++;
                        end
                    end
                    else
                        countdown[i] = countdown[i] - 1'b1;
                end
            end
        end
        r      = pin_snapshot();
        r.kind = KIND_STATUS;
        r.last = (n_done == 0);
        due_results.push_back(r);
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (finished[i])
            begin
                k++;
                r.kind         = KIND_DONE;
                r.done_channel = CHAN_W'(i);
                r.done_code    = code_q[i];
                r.last         = (k == n_done);
                due_results.push_back(r);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [CODE_W-1:0] want,
                               input logic [CODE_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    // compare first: a result seen at an accept edge belongs to an older item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                period_q[i]   = '0;
                countdown[i]  = '0;
                steps_todo[i] = '0;
                code_q[i]     = '0;
                step_lvl[i]   = 1'b0;
                en_lvl[i]     = 1'b1;
                dir_lvl[i]    = 1'b0;
            end
            due_results.delete();
        end
        else
        begin
            if (strobe === 1'b1)
            begin
                if (due_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, got %h", $time, result);
                end
                else
                begin
                    check_field("kind", due_results[0].kind, result.kind);
                    check_field("done_channel", due_results[0].done_channel,
                                result.done_channel);
                    check_field("done_code", due_results[0].done_code, result.done_code);
                    check_field("step_pins", due_results[0].step_pins, result.step_pins);
                    check_field("enable_pins", due_results[0].enable_pins,
                                result.enable_pins);
                    check_field("dir_pins", due_results[0].dir_pins, result.dir_pins);
                    check_field("last", due_results[0].last, result.last);
                    void'(due_results.pop_front());
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                advance_channels(item);
        end
        outstanding = due_results.size();
    end

endmodule

[sim/multi_channel_step_pulse_generator_unit_tb.sv]
// Testbench top for the step pulse generator: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps
module multi_channel_step_pulse_generator_unit_tb import mcspg_pkg::*;
();

    logic    clk = 1'b0;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    strobe;
    result_t result;

    int      mismatches;
    int      outstanding;
    // when clear, commands go back to back; toggled at random for bursts
    bit      gaps_on;

    multi_channel_step_pulse_generator_unit dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .strobe (strobe),
        .result (result)
    );

    // watches both channels, predicts and compares; only hands back counts
    step_pulse_monitor monitor
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .strobe      (strobe),
        .result      (result),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #1 clk = ~clk;

    // Hard stop after 200 us, well beyond the time that the ~130 items need
    // with their random gaps and their results.
    initial
    begin
        #200000;
        $display("end of test: mismatches");
        $finish;
    end

    // Tick items carry random filler in the unused fields so every bit moves.
    function automatic item_t tick_item();
        item_t it;
        it           = item_t'({$urandom, $urandom, $urandom});
        it.opcode    = OP_TICK;
        return it;
    endfunction

    function automatic item_t load_item(input int ch, input logic dir,
                                        input logic [CODE_W-1:0] code,
                                        input int per, input int cnt);
        item_t it;
        it.opcode     = OP_LOAD;
        it.channel    = CHAN_W'(ch);
        it.direction  = dir;
        it.job_code   = code;
        it.period     = PERIOD_W'(per);
        it.step_count = COUNT_W'(cnt);
        return it;
    endfunction

    // Drive one item at a falling edge after a random gap and hold it until
    // the block takes it (start high, busy low at a rising edge). With no gap
    // start simply stays high, so it is never lowered and raised in one step.
    task automatic issue(input item_t it);
        int gap;
        gap = gaps_on ? $urandom_range(0, 17) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy);
    endtask

    initial
    begin
        int per;
        int cnt;
        rst_n   <= 1'b0;
        start   <= 1'b0;
        item    <= '0;
        gaps_on  = 1'b1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed part ----
        // tick with every channel idle: status only
        issue(tick_item());
        // zero step count: done in the same item, enable stays on
        issue(load_item(0, 1'b1, 32'hFFFF_FFFF, 3, 0));
        // widest period and count: all bits high, never finishes here
        issue(load_item(15, 1'b1, $urandom, 16'hFFFF, 24'hFF_FFFF));
        // period two: one plain countdown tick, then a step that ends the task
        issue(load_item(5, 1'b0, $urandom, 2, 1));
        issue(tick_item());
        issue(tick_item());
        // every channel loaded with zero period and one step (overwrites the
        // busy channel 15); the next tick finishes all of them: 17 results
        for (int ch = 0; ch < CHANNELS; ch++)
            issue(load_item(ch, ch[0], (ch == 1) ? 32'h0 : $urandom, 0, 1));
        issue(tick_item());
        issue(tick_item());

        // ---- random part ----
        // about a third loads with mostly short tasks so many complete; a few
        // long periods or counts keep channels busy until they get reloaded
        for (int n = 0; n < 106; n++)
        begin
            if ($urandom_range(0, 19) == 0)
                gaps_on = ~gaps_on;
            if ($urandom_range(0, 99) < 35)
            begin
                case ($urandom_range(0, 9))
                    0:       per = $urandom_range(0, 16'hFFFF);
                    1:       per = $urandom_range(5, 40);
                    default: per = $urandom_range(0, 4);
                endcase
                case ($urandom_range(0, 19))
                    0:       cnt = $urandom_range(0, 24'hFF_FFFF);
                    1, 2:    cnt = $urandom_range(7, 60);
                    default: cnt = $urandom_range(0, 6);
                endcase
                issue(load_item($urandom_range(0, CHANNELS - 1), $urandom_range(0, 1),
                                $urandom, per, cnt));
            end
            else
                issue(tick_item());
        end

        @(negedge clk);
        start <= 1'b0;
        // drain: wait for every expected result, then a full item's latency
        while (outstanding != 0)
            @(negedge clk);
        repeat (CHANNELS + 4) @(negedge clk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
